FILE: hw/rtl/wfp_pkg.sv
// Shared types, constants and datapath commands for the wheel force block.
// Used by wfp_ctrl, wfp_dp and wheel_force_from_position.
package wfp_pkg;

  localparam int SPEED_FRAC_BITS = 8;

  localparam int POS_X_W   = 13;
  localparam int POS_Y_W   = 12;
  localparam int POS_INT_W = 13;
  localparam int ROOT_W    = POS_INT_W + SPEED_FRAC_BITS;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int SUMSQ_W   = 2 * POS_INT_W;
  localparam int ROOT_CNT_W = $clog2(ROOT_W);

  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;

  localparam int SCALE_W    = 17;
  localparam int SCALE_FRAC = 16;
  localparam int SCALE_ONE  = 1 << SCALE_FRAC;
  localparam int SPEED_SAT  = 24 << SPEED_FRAC_BITS;
  localparam int SCALE_SHL  = (SPEED_FRAC_BITS <= 13) ? 13 - SPEED_FRAC_BITS : 0;
  localparam int SCALE_SHR  = (SPEED_FRAC_BITS > 13) ? SPEED_FRAC_BITS - 13 : 0;
  localparam int DIV3_MUL   = 174763;
  localparam int DIV3_SHIFT = 19;

  localparam int STRENGTH_W     = 7;
  localparam int STRENGTH_RESET = 40;
  localparam int STRENGTH_MAX   = 100;
  localparam int COEF_W         = 13;
  localparam int STEER_GAIN     = 55;
  localparam int RUMBLE_ROUGH   = 38;
  localparam int RUMBLE_SMOOTH  = 10;
  localparam int FREQ_BASE      = 18000;
  localparam int FREQ_SPAN      = 24000;

  localparam int RACE_MODE_RACING = 2;
  localparam int RACE_PHASE_MIN   = 3;
  localparam int PAD_RIGHT_BIT    = 6;
  localparam int PAD_LEFT_BIT     = 7;

  localparam int STEER_W  = 14;
  localparam int RUMBLE_W = 12;
  localparam int FREQ_W   = 16;

  typedef struct packed {
    logic        snapshot_ok;
    logic [7:0]  race_mode;
    logic [7:0]  race_phase;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  hit_flag_a;
    logic [7:0]  hit_flag_b;
    logic [7:0]  hit_flag_c;
    logic [7:0]  hit_flag_d;
    logic [7:0]  surface_code;
    logic [15:0] pad_buttons;
  } wfp_in_t;

  typedef struct packed {
    logic signed [STEER_W-1:0] steer_force;
    logic [RUMBLE_W-1:0]       rumble_magnitude;
    logic [FREQ_W-1:0]         rumble_freq_mhz;
    logic                      hit_pulse;
    logic                      is_racing;
  } wfp_out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DELTA,
    OP_SQ_X,
    OP_SQ_Y,
    OP_ROOT_INIT,
    OP_ROOT_STEP,
    OP_SMOOTH,
    OP_SCALE_MUL,
    OP_SCALE,
    OP_MUL_STEER,
    OP_MUL_RUMBLE,
    OP_MUL_FREQ,
    OP_EMIT
  } wfp_op_e;

  typedef struct packed {
    wfp_op_e op;
  } wfp_cmd_t;

  typedef struct packed {
    logic out_free;
  } wfp_stat_t;

endpackage

FILE: hw/rtl/wfp_ctrl.sv
// Sequencer for the wheel force block: steps the datapath through one item.
// Depends on wfp_pkg for the command and status types.
module wfp_ctrl
  import wfp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  wfp_stat_t stat_i,
  output wfp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DELTA,
    S_SQ_X,
    S_SQ_Y,
    S_ROOT_INIT,
    S_ROOT,
    S_SMOOTH,
    S_SCALE_MUL,
    S_SCALE,
    S_MUL_STEER,
    S_MUL_RUMBLE,
    S_MUL_FREQ,
    S_EMIT
  } state_e;

  state_e                state_q, state_d;
  logic [ROOT_CNT_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.op   = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DELTA;
        end
      end
      S_DELTA: begin
        cmd_o.op = OP_DELTA;
        state_d  = S_SQ_X;
      end
      S_SQ_X: begin
        cmd_o.op = OP_SQ_X;
        state_d  = S_SQ_Y;
      end
      S_SQ_Y: begin
        cmd_o.op = OP_SQ_Y;
        state_d  = S_ROOT_INIT;
      end
      S_ROOT_INIT: begin
        cmd_o.op = OP_ROOT_INIT;
        cnt_d    = '0;
        state_d  = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.op = OP_ROOT_STEP;
        if (cnt_q == ROOT_CNT_W'(ROOT_W - 1)) begin
          cnt_d   = '0;
          state_d = S_SMOOTH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SMOOTH: begin
        cmd_o.op = OP_SMOOTH;
        state_d  = S_SCALE_MUL;
      end
      S_SCALE_MUL: begin
        cmd_o.op = OP_SCALE_MUL;
        state_d  = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.op = OP_SCALE;
        state_d  = S_MUL_STEER;
      end
      S_MUL_STEER: begin
        cmd_o.op = OP_MUL_STEER;
        state_d  = S_MUL_RUMBLE;
      end
      S_MUL_RUMBLE: begin
        cmd_o.op = OP_MUL_RUMBLE;
        state_d  = S_MUL_FREQ;
      end
      S_MUL_FREQ: begin
        cmd_o.op = OP_MUL_FREQ;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: hw/rtl/wfp_dp.sv
// Datapath for the wheel force block: deltas, shared multiplier, bit-serial
// square root, speed smoothing, scale and output register. Depends on wfp_pkg.
module wfp_dp
  import wfp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wfp_cmd_t              cmd_i,
  output wfp_stat_t             stat_o,
  input  wfp_in_t               in_data_i,
  input  logic                  cfg_we_i,
  input  logic [STRENGTH_W-1:0] cfg_wdata_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output wfp_out_t              out_data_o
);

  // Architectural state
  logic [STRENGTH_W-1:0] strength_q;
  logic [POS_X_W-1:0]    last_x_q;
  logic [POS_Y_W-1:0]    last_y_q;
  logic                  known_q;
  logic                  hit_q;
  logic [ROOT_W-1:0]     speed_q;
  logic                  out_valid_q;

  // Working registers
  wfp_in_t               item_q;
  logic [POS_X_W-1:0]    dx_mag_q;
  logic [POS_Y_W-1:0]    dy_mag_q;
  logic [COEF_W-1:0]     coef_steer_q;
  logic [COEF_W-1:0]     coef_rumble_q;
  logic [PROD_W-1:0]     prod_q;
  logic [SUMSQ_W-1:0]    sq_x_q;
  logic [RAD_W-1:0]      rad_q;
  logic [REM_W-1:0]      rem_q;
  logic [ROOT_W-1:0]     root_q;
  logic                  pulse_q;
  logic [SCALE_W-1:0]    scale_q;
  logic [STEER_W-1:0]    steer_mag_q;
  logic [RUMBLE_W-1:0]   rumble_q;
  wfp_out_t              out_q;

  logic                  racing;
  logic                  collision;
  logic [POS_X_W-1:0]    x_cur, dx_u, dx_mag;
  logic [POS_Y_W-1:0]    y_cur, dy_u, dy_mag;
  logic [STRENGTH_W-1:0] strength;
  logic [COEF_W-1:0]     rough_gain;
  logic [MUL_W-1:0]      mul_a, mul_b;
  logic [PROD_W-1:0]     mul_p;
  logic [PROD_W-1:0]     scale_wide;
  logic [REM_W-1:0]      rem_next, trial;
  logic [ROOT_W-1:0]     up_step;
  logic [ROOT_W:0]       dn_step;
  logic [ROOT_W-1:0]     smooth_val;
  logic [FREQ_W-1:0]     freq;
  logic signed [STEER_W-1:0] steer;
  wfp_out_t              out_d;

  assign racing = (item_q.race_mode == 8'(RACE_MODE_RACING)) &&
                  (item_q.race_phase >= 8'(RACE_PHASE_MIN));
  assign collision = racing && ((item_q.hit_flag_a != '0) || (item_q.hit_flag_b != '0) ||
                                (item_q.hit_flag_c != '0) || (item_q.hit_flag_d != '0));

  assign x_cur  = item_q.pos_x[POS_X_W-1:0];
  assign y_cur  = item_q.pos_y[POS_Y_W-1:0];
  assign dx_u   = x_cur - last_x_q;
  assign dy_u   = y_cur - last_y_q;
  assign dx_mag = (dx_u <= POS_X_W'(1 << (POS_X_W - 1))) ? dx_u : POS_X_W'(0) - dx_u;
  assign dy_mag = (dy_u <= POS_Y_W'(1 << (POS_Y_W - 1))) ? dy_u : POS_Y_W'(0) - dy_u;

  assign strength   = (strength_q > STRENGTH_W'(STRENGTH_MAX)) ?
                      STRENGTH_W'(STRENGTH_MAX) : strength_q;
  assign rough_gain = (item_q.surface_code != '0) ?
                      COEF_W'(RUMBLE_ROUGH) : COEF_W'(RUMBLE_SMOOTH);

  assign scale_wide = (PROD_W'(speed_q) << SCALE_SHL) >> SCALE_SHR;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_SQ_X: begin
        mul_a = MUL_W'(dx_mag_q);
        mul_b = MUL_W'(dx_mag_q);
      end
      OP_SQ_Y: begin
        mul_a = MUL_W'(dy_mag_q);
        mul_b = MUL_W'(dy_mag_q);
      end
      OP_SCALE_MUL: begin
        mul_a = scale_wide[MUL_W-1:0];
        mul_b = MUL_W'(DIV3_MUL);
      end
      OP_MUL_STEER: begin
        mul_a = MUL_W'(coef_steer_q);
        mul_b = MUL_W'(scale_q);
      end
      OP_MUL_RUMBLE: begin
        mul_a = MUL_W'(coef_rumble_q);
        mul_b = MUL_W'(scale_q);
      end
      OP_MUL_FREQ: begin
        mul_a = MUL_W'(FREQ_SPAN);
        mul_b = MUL_W'(scale_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign rem_next = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial    = {root_q, 2'b01};

  assign up_step    = (root_q - speed_q) >> 2;
  assign dn_step    = ({1'b0, speed_q} - {1'b0, root_q} + (ROOT_W + 1)'(3)) >> 2;
  assign smooth_val = (root_q >= speed_q) ? speed_q + up_step : speed_q - dn_step[ROOT_W-1:0];

  assign freq = FREQ_W'(FREQ_BASE) + prod_q[SCALE_FRAC +: FREQ_W];

  always_comb begin
    if (item_q.pad_buttons[PAD_RIGHT_BIT]) begin
      steer = steer_mag_q;
    end else if (item_q.pad_buttons[PAD_LEFT_BIT]) begin
      steer = STEER_W'(0) - steer_mag_q;
    end else begin
      steer = '0;
    end
  end

  always_comb begin
    out_d = '0;
    if (item_q.snapshot_ok && racing) begin
      out_d.steer_force      = steer;
      out_d.rumble_magnitude = rumble_q;
      out_d.rumble_freq_mhz  = freq;
      out_d.hit_pulse        = pulse_q;
      out_d.is_racing        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q  <= STRENGTH_W'(STRENGTH_RESET);
      last_x_q    <= '0;
      last_y_q    <= '0;
      known_q     <= 1'b0;
      hit_q       <= 1'b0;
      speed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        strength_q <= cfg_wdata_i;
      end
      if (cmd_i.op == OP_SMOOTH && item_q.snapshot_ok) begin
        speed_q  <= (racing && known_q) ? smooth_val : '0;
        last_x_q <= x_cur;
        last_y_q <= y_cur;
        known_q  <= racing;
        hit_q    <= collision;
      end
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        item_q <= in_data_i;
      end
      OP_DELTA: begin
        dx_mag_q      <= dx_mag;
        dy_mag_q      <= dy_mag;
        coef_steer_q  <= COEF_W'(strength) * COEF_W'(STEER_GAIN);
        coef_rumble_q <= COEF_W'(strength) * rough_gain;
      end
      OP_SQ_X: begin
        prod_q <= mul_p;
      end
      OP_SQ_Y: begin
        sq_x_q <= prod_q[SUMSQ_W-1:0];
        prod_q <= mul_p;
      end
      OP_ROOT_INIT: begin
        rad_q  <= {sq_x_q + prod_q[SUMSQ_W-1:0], {(2 * SPEED_FRAC_BITS){1'b0}}};
        rem_q  <= '0;
        root_q <= '0;
      end
      OP_ROOT_STEP: begin
        rad_q <= rad_q << 2;
        if (rem_next >= trial) begin
          rem_q  <= rem_next - trial;
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_next;
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
      end
      OP_SMOOTH: begin
        pulse_q <= collision && !hit_q;
      end
      OP_SCALE_MUL: begin
        prod_q <= mul_p;
      end
      OP_SCALE: begin
        if (speed_q >= ROOT_W'(SPEED_SAT)) begin
          scale_q <= SCALE_W'(SCALE_ONE);
        end else begin
          scale_q <= prod_q[DIV3_SHIFT +: SCALE_W];
        end
      end
      OP_MUL_STEER: begin
        prod_q <= mul_p;
      end
      OP_MUL_RUMBLE: begin
        steer_mag_q <= prod_q[SCALE_FRAC +: STEER_W];
        prod_q      <= mul_p;
      end
      OP_MUL_FREQ: begin
        rumble_q <= prod_q[SCALE_FRAC +: RUMBLE_W];
        prod_q   <= mul_p;
      end
      OP_EMIT: begin
        out_q <= out_d;
      end
      default: begin
        out_q <= out_q;
      end
    endcase
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

FILE: hw/rtl/wheel_force_from_position.sv
// Top level of the wheel force block: joins the sequencer and the datapath.
// Depends on wfp_pkg, wfp_ctrl and wfp_dp.
//
// Usage:
//   One input item per video frame arrives on the in channel (valid/ready),
//   carrying the race snapshot. One result item per input leaves on the out
//   channel (valid/ready). The strength register is written through
//   cfg_we_i/cfg_wdata_i; the user must write it only while no item is in
//   flight, as the block itself does not enforce this. Each result is built
//   by the 21 one-bit-per-cycle square root steps and the shared 18x18
//   multiplier used six times. A new item is not taken until the last one has
//   been emitted; in_ready_o is high only while the sequencer is idle.
//   The result sits in an output register; a stalled receiver holds it, and
//   the next item is still accepted and worked on, waiting at its last step
//   until the register frees.
//   Reset clears speed, positions and collision history, drops any pending
//   result and sets strength to 40 percent.
module wheel_force_from_position
  import wfp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  wfp_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output wfp_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [STRENGTH_W-1:0] cfg_wdata_i
);

  wfp_cmd_t  cmd;
  wfp_stat_t stat;

  wfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wfp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for wheel_force_from_position: directed and random frames,
// with a built-in predictor of speed, scale and force outputs and a strength register sweep.
// Depends on wfp_pkg and the wheel_force_from_position RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wfp_pkg::*;

  localparam int          FRAC          = 8;
  localparam int          X_MOD         = 8192;
  localparam int          Y_MOD         = 4096;
  localparam int          ONE_Q16       = 65536;
  localparam int          SAT_SPEED     = 24;
  localparam int          PCT_MAX       = 100;
  localparam int          GAIN_STEER    = 55;
  localparam int          GAIN_ROUGH    = 38;
  localparam int          GAIN_SMOOTH   = 10;
  localparam int          FREQ_FLOOR    = 18000;
  localparam int          FREQ_RANGE    = 24000;
  localparam int          MODE_RACING   = 2;
  localparam int          PHASE_RACING  = 3;
  localparam int          BIT_RIGHT     = 6;
  localparam int          BIT_LEFT      = 7;
  localparam logic [15:0] PAD_RIGHT     = 16'h0040;
  localparam logic [15:0] PAD_LEFT      = 16'h0080;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          DONE_CYCLES   = 48;
  localparam int          MAX_PRINTS    = 30;

  logic                  clk_i;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  wfp_in_t               in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [STRENGTH_W-1:0] cfg_wdata = '0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  wfp_out_t              out_data_o;

  wheel_force_from_position u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // predictor state
  int unsigned     strength_q  = 40;
  logic [12:0]     last_x_q    = '0;
  logic [11:0]     last_y_q    = '0;
  logic            pos_known_q = 1'b0;
  longint unsigned speed_q     = 0;
  logic            hit_q       = 1'b0;

  wfp_out_t force_expected[$];
  int       mismatches = 0;
  bit       gaps_on    = 1'b1;
  int       hold_off   = 0;
  int       stall_left = 0;
  int       cur_x      = 0;
  int       cur_y      = 0;
  int       crash_left = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'h1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    -= root + probe;
        root  = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic int wrap_step(int cur, int prev, int modulus);
    int d;
    d = cur - prev;
    if (d > modulus / 2) d -= modulus;
    if (d < -(modulus / 2)) d += modulus;
    return d;
  endfunction

  function automatic wfp_out_t predict_force(wfp_in_t f);
    wfp_out_t            res;
    longint unsigned     pct;
    longint unsigned     gain;
    longint unsigned     inst;
    longint unsigned     scale;
    longint unsigned     mag;
    longint unsigned     rumble;
    longint unsigned     freq;
    logic [STEER_W-1:0]  mag14;
    logic                racing;
    logic                hit;
    logic                pulse;
    int                  dx;
    int                  dy;
    res = '0;
    if (!f.snapshot_ok) return res;
    pct    = (strength_q > PCT_MAX) ? PCT_MAX : strength_q;
    racing = (f.race_mode == MODE_RACING) && (f.race_phase >= PHASE_RACING);
    if (racing && pos_known_q) begin
      dx   = wrap_step(int'(f.pos_x[12:0]), int'(last_x_q), X_MOD);
      dy   = wrap_step(int'(f.pos_y[11:0]), int'(last_y_q), Y_MOD);
      inst = int_sqrt(longint'(dx * dx + dy * dy) << (2 * FRAC));
      if (inst >= speed_q) speed_q += (inst - speed_q) >> 2;
      else speed_q -= (speed_q - inst + 3) >> 2;
    end else begin
      speed_q = 0;
    end
    last_x_q    = f.pos_x[12:0];
    last_y_q    = f.pos_y[11:0];
    pos_known_q = racing;
    hit = racing && (f.hit_flag_a != 0 || f.hit_flag_b != 0 ||
                     f.hit_flag_c != 0 || f.hit_flag_d != 0);
    pulse = hit && !hit_q;
    hit_q = hit;
    if (!racing) return res;
    res.hit_pulse = pulse;
    res.is_racing = 1'b1;
    scale = (speed_q << 16) / (longint'(SAT_SPEED) << FRAC);
    if (scale > ONE_Q16) scale = ONE_Q16;
    mag   = (pct * GAIN_STEER * scale) >> 16;
    mag14 = mag[STEER_W-1:0];
    if (f.pad_buttons[BIT_RIGHT]) res.steer_force = mag14;
    else if (f.pad_buttons[BIT_LEFT]) res.steer_force = -mag14;
    else res.steer_force = '0;
    gain   = (f.surface_code != 0) ? GAIN_ROUGH : GAIN_SMOOTH;
    rumble = (pct * gain * scale) >> 16;
    res.rumble_magnitude = rumble[RUMBLE_W-1:0];
    freq = FREQ_FLOOR + ((scale * FREQ_RANGE) >> 16);
    res.rumble_freq_mhz = freq[FREQ_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < MAX_PRINTS)
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_results
    wfp_out_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (force_expected.size() == 0) begin
        report_mismatch("unexpected item, is_racing", out_data_o.is_racing, 0);
      end else begin
        want = force_expected.pop_front();
        if (out_data_o.steer_force != want.steer_force)
          report_mismatch("steer_force", out_data_o.steer_force, want.steer_force);
        if (out_data_o.rumble_magnitude != want.rumble_magnitude)
          report_mismatch("rumble_magnitude", out_data_o.rumble_magnitude,
                          want.rumble_magnitude);
        if (out_data_o.rumble_freq_mhz != want.rumble_freq_mhz)
          report_mismatch("rumble_freq_mhz", out_data_o.rumble_freq_mhz,
                          want.rumble_freq_mhz);
        if (out_data_o.hit_pulse != want.hit_pulse)
          report_mismatch("hit_pulse", out_data_o.hit_pulse, want.hit_pulse);
        if (out_data_o.is_racing != want.is_racing)
          report_mismatch("is_racing", out_data_o.is_racing, want.is_racing);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (gaps_on) stall_left <= pick_gap();
    end
  end

  task automatic send_frame(input wfp_in_t frame);
    repeat (hold_off) @(negedge clk_i);
    in_data  <= frame;
    in_valid <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    force_expected.push_back(predict_force(frame));
    @(negedge clk_i);
    hold_off = gaps_on ? pick_gap() : 0;
    if (hold_off != 0) in_valid <= 1'b0;
  endtask

  task automatic drain(input int settle);
    if (hold_off == 0) in_valid <= 1'b0;
    hold_off = 0;
    while (force_expected.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic set_strength(input int unsigned pct);
    drain(SETTLE_CYCLES);
    cfg_wdata  <= pct[STRENGTH_W-1:0];
    cfg_we     <= 1'b1;
    strength_q  = pct & 32'h7f;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic wfp_in_t race_frame(logic [7:0] mode, logic [7:0] phase,
                                         logic [15:0] x, logic [15:0] y,
                                         logic [31:0] hits, logic [7:0] surface,
                                         logic [15:0] pad);
    wfp_in_t f;
    f.snapshot_ok  = 1'b1;
    f.race_mode    = mode;
    f.race_phase   = phase;
    f.pos_x        = x;
    f.pos_y        = y;
    f.hit_flag_a   = hits[31:24];
    f.hit_flag_b   = hits[23:16];
    f.hit_flag_c   = hits[15:8];
    f.hit_flag_d   = hits[7:0];
    f.surface_code = surface;
    f.pad_buttons  = pad;
    return f;
  endfunction

  function automatic int pick_step(int modulus);
    int s;
    case ($urandom_range(0, 9))
      0:       s = 0;
      1, 2, 3: s = $urandom_range(0, 8);
      4, 5, 6: s = $urandom_range(0, 40);
      7, 8:    s = $urandom_range(0, 400);
      default: s = $urandom_range(0, modulus - 1);
    endcase
    if ($urandom_range(0, 1)) s = -s;
    return s;
  endfunction

  function automatic wfp_in_t random_frame();
    wfp_in_t     f;
    logic [31:0] hits;
    int          r;
    f = wfp_in_t'({$urandom, $urandom, $urandom, $urandom});
    r = $urandom_range(0, 99);
    if (r < 80) begin
      cur_x = (cur_x + pick_step(X_MOD)) & (X_MOD - 1);
      cur_y = (cur_y + pick_step(Y_MOD)) & (Y_MOD - 1);
      hits  = 0;
      if (crash_left > 0) begin
        crash_left--;
        hits = $urandom;
        if (hits == 0) hits = 32'h1;
      end else if ($urandom_range(0, 14) == 0) begin
        crash_left = $urandom_range(1, 6);
      end
      f = race_frame(MODE_RACING,
                     8'(($urandom_range(0, 3) == 0) ? $urandom_range(3, 255) :
                                                      $urandom_range(3, 6)),
                     {3'($urandom), 13'(cur_x)}, {4'($urandom), 12'(cur_y)}, hits,
                     ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'h00,
                     16'($urandom));
    end else if (r < 90) begin
      f.snapshot_ok = 1'b1;
      if ($urandom_range(0, 1)) begin
        f.race_mode  = MODE_RACING;
        f.race_phase = 8'($urandom_range(0, 2));
      end else if (f.race_mode == MODE_RACING) begin
        f.race_mode = 8'hff;
      end
    end else if (r < 95) begin
      f.snapshot_ok = 1'b0;
    end
    return f;
  endfunction

  task automatic test_directed();
    wfp_in_t f;
    f = '1;
    f.snapshot_ok = 1'b0;
    send_frame(f);
    send_frame(race_frame(2, 2, 100, 100, 0, 0, PAD_RIGHT));
    send_frame(race_frame(3, 3, 100, 100, 0, 0, PAD_RIGHT));
    send_frame(race_frame(2, 3, 100, 100, 0, 0, PAD_RIGHT));
    send_frame(race_frame(2, 3, 130, 120, 0, 0, PAD_RIGHT));
    send_frame(race_frame(2, 4, 160, 140, 0, 8'hff, PAD_LEFT));
    send_frame(race_frame(2, 4, 160, 140, 0, 8'h01, PAD_RIGHT | PAD_LEFT));
    send_frame(race_frame(2, 4, 161, 140, 0, 0, 16'hff3f));
    f = race_frame(2, 4, 900, 900, 32'hffffffff, 8'hff, PAD_RIGHT);
    f.snapshot_ok = 1'b0;
    send_frame(f);
    send_frame(race_frame(2, 255, 162, 141, 32'h01000000, 0, PAD_RIGHT));
    send_frame(race_frame(2, 255, 163, 142, 32'h00800000, 0, PAD_RIGHT));
    send_frame(race_frame(2, 3, 164, 143, 0, 0, PAD_RIGHT));
    send_frame(race_frame(2, 3, 165, 144, 32'h0000ff00, 0, PAD_LEFT));
    send_frame(race_frame(2, 3, 166, 145, 32'h00000010, 0, PAD_LEFT));
    send_frame(race_frame(2, 3, 16'he000, 16'hf000, 0, 0, PAD_RIGHT));
    send_frame(race_frame(2, 3, 4096, 2048, 0, 0, PAD_RIGHT));
    send_frame(race_frame(2, 3, 0, 0, 0, 0, PAD_LEFT));
    send_frame(race_frame(2, 3, 4097, 2049, 0, 0, PAD_RIGHT));
    send_frame(race_frame(2, 3, 16'he000, 16'hf000, 0, 8'hff, PAD_LEFT));
    send_frame(race_frame(2, 3, 16'hffff, 16'hffff, 0, 0, PAD_RIGHT));
    send_frame(race_frame(2, 3, 0, 0, 0, 0, PAD_RIGHT));
    send_frame(race_frame(8'hff, 8'hff, 0, 0, 32'hffffffff, 0, PAD_RIGHT));
    send_frame(race_frame(2, 3, 0, 0, 32'hffffffff, 0, PAD_RIGHT));
  endtask

  task automatic test_strength_range();
    int unsigned levels[6] = '{0, 1, 100, 101, 127, 64};
    foreach (levels[i]) begin
      set_strength(levels[i]);
      for (int k = 0; k < 12; k++) begin
        cur_x = (cur_x + 10 + 12 * k) & (X_MOD - 1);
        cur_y = (cur_y + 7 * k) & (Y_MOD - 1);
        send_frame(race_frame(2, 3, 16'(cur_x), 16'(cur_y), 0, 8'(k % 2),
                              (k % 3 == 0) ? PAD_LEFT : PAD_RIGHT));
      end
    end
  endtask

  task automatic test_random();
    int unsigned pct;
    for (int blk = 0; blk < 10; blk++) begin
      case ($urandom_range(0, 3))
        0:       pct = ($urandom_range(0, 1) != 0) ? 127 : 0;
        1:       pct = 100;
        default: pct = $urandom_range(0, 127);
      endcase
      set_strength(pct);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (150) send_frame(random_frame());
      gaps_on = 1'b1;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_strength_range();
    test_random();
    drain(DONE_CYCLES);
    if (mismatches == 0 && force_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/wfp_pkg.sv
hw/rtl/wfp_ctrl.sv
hw/rtl/wfp_dp.sv
hw/rtl/wheel_force_from_position.sv
test/testbench.sv
